>>> rtl/ctt_pkg.sv
// Shared types and codes for the countdown timer table.
// No dependencies; used by every module of the block and by its checker.
`default_nettype none

package ctt_pkg;

    // Command codes (input tuser)
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Result kinds (output tuser)
    localparam logic [2:0] KIND_FIRED     = 3'd0;
    localparam logic [2:0] KIND_APPENDED  = 3'd1;
    localparam logic [2:0] KIND_REJECTED  = 3'd2;
    localparam logic [2:0] KIND_CLEARED   = 3'd3;
    localparam logic [2:0] KIND_TICK_IDLE = 3'd4;

    localparam int CMD_W     = 2;
    localparam int HANDLER_W = 8;
    localparam int TAG_W     = 16;
    localparam int DELAY_W   = 16;
    localparam int KIND_W    = 3;
    localparam int RCOUNT_W  = 5;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 32;

    // One classified command on its way to the back end
    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [HANDLER_W-1:0] handler;
        logic [TAG_W-1:0]     tag;
        logic [DELAY_W-1:0]   delay;
    } t_job;

    // One pending timer
    typedef struct packed {
        logic [DELAY_W-1:0]   remaining;
        logic [HANDLER_W-1:0] handler;
        logic [TAG_W-1:0]     tag;
    } t_timer;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [HANDLER_W-1:0] handler;
        logic [TAG_W-1:0]     tag;
        logic [RCOUNT_W-1:0]  removed;
        logic                 last;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/countdown_timer_table.sv
// Top level of the countdown timer table; joins front end, queue and back end.
// Depends on ctt_pkg, ctt_front, ctt_queue and ctt_back.
`default_nettype none

// Holds up to TIMER_SLOTS countdown timers in newest-first order. Commands
// arrive on the slave stream (tuser = command), results leave on the master
// stream (tuser = kind, tlast on the final result of a command). A two-entry
// queue lets the input keep taking transfers while the back end works or the
// output is stalled. An append is done straight from the idle state. A clear
// or a tick walks the live timers one per cycle through the head of the list
// (held while the output stalls with a fired timer waiting), so it occupies
// the back end for the whole walk; that walk sets the throughput. The unused
// command code is accepted and produces nothing. Fired timers come out in list
// order, one result each; the last one carries tlast.
module countdown_timer_table #(
    parameter int TIMER_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // handler_id[7:0], tag[23:8], delay[39:24]
    input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // fired_handler[7:0], fired_tag[23:8],
                                            // removed_count[28:24], zero[31:29]
    output logic [2:0]       m_axis_tuser,  // kind[2:0]
    output logic             m_axis_tlast
);

    ctt_pkg::t_job    w_front_job, w_q_job;
    ctt_pkg::t_result w_res;
    logic             w_push, w_q_ready, w_q_valid, w_pop;

    ctt_front u_front (
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_cmd     (s_axis_tuser),
        .i_data    (s_axis_tdata),
        .o_q_valid (w_push),
        .i_q_ready (w_q_ready),
        .o_job     (w_front_job)
    );

    ctt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .i_job   (w_front_job),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_job   (w_q_job)
    );

    ctt_back #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_pop),
        .i_job     (w_q_job),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (w_res)
    );

    // Pack the result onto the master stream
    assign m_axis_tdata = {3'b000, w_res.removed, w_res.tag, w_res.handler};
    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;

endmodule

`default_nettype wire

>>> rtl/ctt_front.sv
// Front end: unpacks and classifies incoming transfers, drops unused commands.
// Depends on ctt_pkg.
`default_nettype none

module ctt_front (
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [ctt_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [ctt_pkg::S_DATA_W-1:0]  i_data,
    output logic                               o_q_valid,
    input  wire logic                          i_q_ready,
    output ctt_pkg::t_job                      o_job
);

    logic w_keep;

    // Unused command code is taken and discarded: it yields no result.
    assign w_keep    = (i_cmd != ctt_pkg::CMD_UNUSED);
    assign o_ready   = i_q_ready;
    assign o_q_valid = i_valid && w_keep;

    always_comb begin
        o_job.cmd     = i_cmd;
        o_job.handler = i_data[7:0];
        o_job.tag     = i_data[23:8];
        o_job.delay   = i_data[39:24];
    end

endmodule

`default_nettype wire

>>> rtl/ctt_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on ctt_pkg.
`default_nettype none

module ctt_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_ready,
    input  wire ctt_pkg::t_job i_job,
    output logic               o_valid,
    input  wire logic          i_pop,
    output ctt_pkg::t_job      o_job
);

    ctt_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_wr, w_rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_job;
    end

endmodule

`default_nettype wire

>>> rtl/ctt_back.sv
// Back end: timer list, walk sequencer for clear and tick, result register.
// Depends on ctt_pkg.
`default_nettype none

module ctt_back #(
    parameter int TIMER_SLOTS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    output logic               o_q_pop,
    input  wire ctt_pkg::t_job i_job,
    output logic               o_valid,
    input  wire logic          i_ready,
    output ctt_pkg::t_result   o_res
);

    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int RW = ctt_pkg::RCOUNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // List kept packed in order, newest first; r_used entries are live.
    ctt_pkg::t_timer r_tab [TIMER_SLOTS];
    ctt_pkg::t_timer n_tab [TIMER_SLOTS];

    logic [1:0]                   r_state, n_state;
    logic [CW-1:0]                r_used, n_used;
    logic [ctt_pkg::CMD_W-1:0]    r_op, n_op;
    logic [ctt_pkg::TAG_W-1:0]    r_match, n_match;
    logic [CW-1:0]                r_left, n_left;
    logic [CW-1:0]                r_keep, n_keep;
    logic [CW-1:0]                r_removed, n_removed;
    logic                         r_held_v, n_held_v;
    logic [ctt_pkg::HANDLER_W-1:0] r_held_h, n_held_h;
    logic [ctt_pkg::TAG_W-1:0]    r_held_t, n_held_t;
    logic                         r_out_valid;
    ctt_pkg::t_result             r_out;

    ctt_pkg::t_timer  w_head, w_kept, w_new;
    ctt_pkg::t_result w_res;
    logic             w_push, w_hit, w_fire, w_step, w_out_free, w_full;
    logic [CW-1:0]    w_wpos_full;
    logic [IW-1:0]    w_wpos;
    logic [RW+CW-1:0] w_removed_ext;

    assign w_out_free    = !r_out_valid || i_ready;
    assign w_full        = (r_used == CW'(TIMER_SLOTS));
    assign w_head        = r_tab[0];
    assign w_hit         = (r_op == ctt_pkg::CMD_CLEAR) ? (w_head.tag == r_match)
                                                        : (w_head.remaining == '0);
    assign w_fire        = (r_op == ctt_pkg::CMD_TICK) && w_hit;
    // A second firing needs the held one moved out first.
    assign w_step        = (r_state == ST_WALK) && (r_left != '0)
                           && !(w_fire && r_held_v && !w_out_free);
    // Kept entry goes behind the not yet walked ones and those kept before.
    assign w_wpos_full   = r_left - CW'(1) + r_keep;
    assign w_wpos        = w_wpos_full[IW-1:0];
    assign w_removed_ext = {{RW{1'b0}}, r_removed};

    always_comb begin
        w_kept = w_head;
        if (r_op == ctt_pkg::CMD_TICK) w_kept.remaining = w_head.remaining - 16'd1;
        w_new.remaining = i_job.delay;
        w_new.handler   = i_job.handler;
        w_new.tag       = i_job.tag;
    end

    always_comb begin
        n_tab     = r_tab;
        n_state   = r_state;
        n_used    = r_used;
        n_op      = r_op;
        n_match   = r_match;
        n_left    = r_left;
        n_keep    = r_keep;
        n_removed = r_removed;
        n_held_v  = r_held_v;
        n_held_h  = r_held_h;
        n_held_t  = r_held_t;
        o_q_pop   = 1'b0;
        w_push    = 1'b0;
        w_res     = '0;
        w_res.last = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_job.cmd == ctt_pkg::CMD_APPEND) begin
                        if (w_out_free) begin
                            o_q_pop = 1'b1;
                            w_push  = 1'b1;
                            if (w_full) begin
                                w_res.kind = ctt_pkg::KIND_REJECTED;
                            end else begin
                                w_res.kind = ctt_pkg::KIND_APPENDED;
                                for (int i = TIMER_SLOTS - 1; i > 0; i--)
                                    n_tab[i] = r_tab[i-1];
                                n_tab[0] = w_new;
                                n_used   = r_used + CW'(1);
                            end
                        end
                    end else begin
                        o_q_pop   = 1'b1;
                        n_op      = i_job.cmd;
                        n_match   = i_job.tag;
                        n_left    = r_used;
                        n_keep    = '0;
                        n_removed = '0;
                        n_held_v  = 1'b0;
                        n_state   = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (r_left == '0) begin
                    n_used  = r_keep;
                    n_state = ST_DONE;
                end else if (w_step) begin
                    for (int i = 0; i < TIMER_SLOTS - 1; i++)
                        n_tab[i] = r_tab[i+1];
                    n_left = r_left - CW'(1);
                    if (w_hit) begin
                        if (w_fire) begin
                            if (r_held_v) begin
                                w_push        = 1'b1;
                                w_res.kind    = ctt_pkg::KIND_FIRED;
                                w_res.handler = r_held_h;
                                w_res.tag     = r_held_t;
                                w_res.last    = 1'b0;
                            end
                            n_held_v = 1'b1;
                            n_held_h = w_head.handler;
                            n_held_t = w_head.tag;
                        end else begin
                            n_removed = r_removed + CW'(1);
                        end
                    end else begin
                        n_tab[w_wpos] = w_kept;
                        n_keep        = r_keep + CW'(1);
                    end
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_push  = 1'b1;
                    n_state = ST_IDLE;
                    if (r_op == ctt_pkg::CMD_CLEAR) begin
                        w_res.kind    = ctt_pkg::KIND_CLEARED;
                        w_res.removed = w_removed_ext[RW-1:0];
                    end else if (r_held_v) begin
                        w_res.kind    = ctt_pkg::KIND_FIRED;
                        w_res.handler = r_held_h;
                        w_res.tag     = r_held_t;
                    end else begin
                        w_res.kind = ctt_pkg::KIND_TICK_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_held_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_held_v <= n_held_v;
            if (w_push)       r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tab     <= n_tab;
        r_op      <= n_op;
        r_match   <= n_match;
        r_left    <= n_left;
        r_keep    <= n_keep;
        r_removed <= n_removed;
        r_held_h  <= n_held_h;
        r_held_t  <= n_held_t;
        if (w_push) r_out <= w_res;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

`default_nettype wire

>>> rtl/ctt_checker.sv
// Port-level checker for the countdown timer table, bound to the top level.
// Depends on ctt_pkg and countdown_timer_table.
`default_nettype none

module ctt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Only fired results may leave a command open
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ctt_pkg::KIND_FIRED |-> m_axis_tlast)
        else $error("non-fired result without tlast");

    // Handler and tag only on fired results
    a_fired_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ctt_pkg::KIND_FIRED
            |-> m_axis_tdata[23:0] == 24'd0)
        else $error("handler or tag set on non-fired result");

    // Removed count only on clear results
    a_count_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ctt_pkg::KIND_CLEARED
            |-> m_axis_tdata[31:24] == 8'd0)
        else $error("removed count set on non-clear result");

    // After a non-final fired result, another fired result follows
    a_fire_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !m_axis_tvalid || m_axis_tuser == ctt_pkg::KIND_FIRED)
        else $error("open fired run broken by another kind");

endmodule

bind countdown_timer_table ctt_checker u_ctt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
